FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker module.
// Depends on nothing; included by name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define KALC_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define KALC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/kalc_pkg.sv
// Types and constants for the key auto-repeat level controller.
// Used by every module of the block; depends on nothing.
package kalc_pkg;

  localparam int LEVEL_BITS     = 6;
  localparam int MS_BITS        = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int KEY_CODE_BITS  = 10;

  typedef logic [LEVEL_BITS-1:0] level_t;
  typedef logic [MS_BITS-1:0]    ms_t;

  typedef enum logic [1:0] {
    OP_FRAME_BEGIN = 2'd0,
    OP_KEY_EVENT   = 2'd1,
    OP_FRAME_END   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KEY_RELEASED = 2'd0,
    KEY_PRESSED  = 2'd1,
    KEY_REPEAT   = 2'd2,
    KEY_IGNORED  = 2'd3
  } key_value_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_VOLUME_MAX      = 3'd0,
    REG_BRIGHTNESS_MAX  = 3'd1,
    REG_VOLUME_INIT     = 3'd2,
    REG_BRIGHTNESS_INIT = 3'd3,
    REG_FIRST_DELAY     = 3'd4,
    REG_REPEAT_INTERVAL = 3'd5,
    REG_SLEEP_GAP       = 3'd6
  } cfg_reg_t;

  localparam logic [KEY_CODE_BITS-1:0] KEY_MENU  = 10'd312;
  localparam logic [KEY_CODE_BITS-1:0] KEY_PLUS  = 10'd115;
  localparam logic [KEY_CODE_BITS-1:0] KEY_MINUS = 10'd114;

  localparam level_t RST_VOLUME_MAX      = 6'd20;
  localparam level_t RST_BRIGHTNESS_MAX  = 6'd10;
  localparam level_t RST_VOLUME_INIT     = 6'd0;
  localparam level_t RST_BRIGHTNESS_INIT = 6'd0;
  localparam ms_t    RST_FIRST_DELAY     = 16'd300;
  localparam ms_t    RST_REPEAT_INTERVAL = 16'd100;
  localparam ms_t    RST_SLEEP_GAP       = 16'd1000;

  typedef struct packed {
    logic up;
    logic down;
  } step_req_t;

endpackage

FILE: hw/rtl/kalc_level_step.sv
// Saturating up-then-down step of one level register.
// Depends on kalc_pkg for the level and step request types.
module kalc_level_step (
  input  kalc_pkg::level_t    level,
  input  kalc_pkg::level_t    level_max,
  input  kalc_pkg::step_req_t req,
  output kalc_pkg::level_t    level_next,
  output logic                changed
);
  import kalc_pkg::*;

  logic   up_ok;
  logic   down_ok;
  level_t level_up;

  always_comb begin
    up_ok      = req.up && (level < level_max);
    level_up   = up_ok ? level + level_t'(1) : level;
    down_ok    = req.down && (level_up != '0);
    level_next = down_ok ? level_up - level_t'(1) : level_up;
    changed    = up_ok || down_ok;
  end

endmodule

FILE: hw/rtl/key_autorepeat_level_control_core.sv
// Key auto-repeat level controller: top level.
// Depends on kalc_pkg and kalc_level_step.
//   Input channel (in_valid/in_ready) carries one request per item: a
//   frame begin with now_ms, a key event, or a frame end. Each accepted
//   request yields exactly one result on the output channel
//   (out_valid/out_ready): the volume and brightness levels after it and
//   flags set when a frame end stepped a level.
//   The result is registered at the accepting edge and shown from the
//   next cycle. Throughput is one request per cycle while the receiver
//   does not stall; the limit is the single result register, which
//   takes a new result in the cycle its old one leaves.
//   When the receiver stalls, the result holds and in_ready falls until
//   out_ready returns; nothing is lost or repeated.
//   Reset (rst, synchronous) clears all key state, loads the register
//   reset values, sets both levels to their initial values and empties
//   the result register.
//   Configuration: cfg_we with cfg_index and cfg_data writes one register
//   at once; writing an initial level also loads that level. Write only
//   while no request is in flight.
module key_autorepeat_level_control_core #(
  parameter int TIME_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [kalc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [kalc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           op,
  input  logic                                 is_key_event,
  input  logic [kalc_pkg::KEY_CODE_BITS-1:0]   key_code,
  input  logic [1:0]                           key_value,
  input  logic [31:0]                          now_ms,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output kalc_pkg::level_t                     volume,
  output kalc_pkg::level_t                     brightness,
  output logic                                 volume_changed,
  output logic                                 brightness_changed
);
  import kalc_pkg::*;

  typedef logic [TIME_BITS-1:0] time_t;

  level_t volume_limit, brightness_limit;
  ms_t    first_delay_ms, repeat_interval_ms, sleep_gap_ms;

  logic  menu_held, up_held, up_fresh, down_held, down_fresh;
  logic  have_previous, skip_frame;
  time_t up_next_ms, down_next_ms, frame_time_ms, previous_frame_ms;
  level_t volume_level, brightness_level;

  logic  menu_held_next, up_held_next, up_fresh_next, down_held_next, down_fresh_next;
  logic  have_previous_next, skip_frame_next;
  time_t up_next_ms_next, down_next_ms_next, frame_time_ms_next, previous_frame_ms_next;

  logic      accept;
  logic      key_on;
  logic      m_held, u_held, u_fresh, d_held, d_fresh;
  logic      up_due, down_due;
  time_t     now_t, gap, armed, u_next, d_next;
  step_req_t step, vol_req, bri_req;
  level_t    volume_level_next, brightness_level_next;
  logic      vol_step_changed, bri_step_changed;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign now_t    = time_t'(now_ms);
  assign gap      = now_t - previous_frame_ms;
  assign armed    = frame_time_ms + time_t'(first_delay_ms);
  assign key_on   = (key_value != KEY_RELEASED);

  always_comb begin
    menu_held_next         = menu_held;
    up_held_next           = up_held;
    up_fresh_next          = up_fresh;
    down_held_next         = down_held;
    down_fresh_next        = down_fresh;
    have_previous_next     = have_previous;
    skip_frame_next        = skip_frame;
    up_next_ms_next        = up_next_ms;
    down_next_ms_next      = down_next_ms;
    frame_time_ms_next     = frame_time_ms;
    previous_frame_ms_next = previous_frame_ms;
    step                   = '0;

    m_held  = skip_frame ? 1'b0 : menu_held;
    u_held  = skip_frame ? 1'b0 : up_held;
    u_fresh = skip_frame ? 1'b0 : up_fresh;
    d_held  = skip_frame ? 1'b0 : down_held;
    d_fresh = skip_frame ? 1'b0 : down_fresh;
    u_next  = skip_frame ? '0 : up_next_ms;
    d_next  = skip_frame ? '0 : down_next_ms;
    up_due   = u_fresh || (u_held && (frame_time_ms >= u_next));
    down_due = d_fresh || (d_held && (frame_time_ms >= d_next));

    case (op)
      OP_FRAME_BEGIN: begin
        frame_time_ms_next = now_t;
        skip_frame_next    = have_previous && (gap > time_t'(sleep_gap_ms));
      end
      OP_KEY_EVENT: begin
        if (!skip_frame && is_key_event && (key_value != KEY_IGNORED)) begin
          if (key_code == KEY_MENU) begin
            menu_held_next = key_on;
          end else if (key_code == KEY_PLUS) begin
            up_held_next  = key_on;
            up_fresh_next = key_on;
            if (key_on) begin
              up_next_ms_next = armed;
            end
          end else if (key_code == KEY_MINUS) begin
            down_held_next  = key_on;
            down_fresh_next = key_on;
            if (key_on) begin
              down_next_ms_next = armed;
            end
          end
        end
      end
      OP_FRAME_END: begin
        step.up           = up_due;
        step.down         = down_due;
        menu_held_next    = m_held;
        up_held_next      = u_held;
        down_held_next    = d_held;
        up_fresh_next     = up_due ? 1'b0 : u_fresh;
        down_fresh_next   = down_due ? 1'b0 : d_fresh;
        up_next_ms_next   = (up_due && !u_fresh) ? u_next + time_t'(repeat_interval_ms)
                                                 : u_next;
        down_next_ms_next = (down_due && !d_fresh) ? d_next + time_t'(repeat_interval_ms)
                                                   : d_next;
        previous_frame_ms_next = frame_time_ms;
        have_previous_next     = 1'b1;
        skip_frame_next        = 1'b0;
      end
      default: begin
      end
    endcase

    vol_req = m_held ? '0 : step;
    bri_req = m_held ? step : '0;
  end

  kalc_level_step u_vol_step (
    .level      (volume_level),
    .level_max  (volume_limit),
    .req        (vol_req),
    .level_next (volume_level_next),
    .changed    (vol_step_changed)
  );

  kalc_level_step u_bri_step (
    .level      (brightness_level),
    .level_max  (brightness_limit),
    .req        (bri_req),
    .level_next (brightness_level_next),
    .changed    (bri_step_changed)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_limit       <= RST_VOLUME_MAX;
      brightness_limit   <= RST_BRIGHTNESS_MAX;
      first_delay_ms     <= RST_FIRST_DELAY;
      repeat_interval_ms <= RST_REPEAT_INTERVAL;
      sleep_gap_ms       <= RST_SLEEP_GAP;
      volume_level       <= RST_VOLUME_INIT;
      brightness_level   <= RST_BRIGHTNESS_INIT;
    end else begin
      if (accept) begin
        volume_level     <= volume_level_next;
        brightness_level <= brightness_level_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_VOLUME_MAX:      volume_limit       <= cfg_data[LEVEL_BITS-1:0];
          REG_BRIGHTNESS_MAX:  brightness_limit   <= cfg_data[LEVEL_BITS-1:0];
          REG_VOLUME_INIT:     volume_level       <= cfg_data[LEVEL_BITS-1:0];
          REG_BRIGHTNESS_INIT: brightness_level   <= cfg_data[LEVEL_BITS-1:0];
          REG_FIRST_DELAY:     first_delay_ms     <= cfg_data[MS_BITS-1:0];
          REG_REPEAT_INTERVAL: repeat_interval_ms <= cfg_data[MS_BITS-1:0];
          REG_SLEEP_GAP:       sleep_gap_ms       <= cfg_data[MS_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      menu_held         <= 1'b0;
      up_held           <= 1'b0;
      up_fresh          <= 1'b0;
      down_held         <= 1'b0;
      down_fresh        <= 1'b0;
      have_previous     <= 1'b0;
      skip_frame        <= 1'b0;
      up_next_ms        <= '0;
      down_next_ms      <= '0;
      frame_time_ms     <= '0;
      previous_frame_ms <= '0;
    end else if (accept) begin
      menu_held         <= menu_held_next;
      up_held           <= up_held_next;
      up_fresh          <= up_fresh_next;
      down_held         <= down_held_next;
      down_fresh        <= down_fresh_next;
      have_previous     <= have_previous_next;
      skip_frame        <= skip_frame_next;
      up_next_ms        <= up_next_ms_next;
      down_next_ms      <= down_next_ms_next;
      frame_time_ms     <= frame_time_ms_next;
      previous_frame_ms <= previous_frame_ms_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      volume             <= volume_level_next;
      brightness         <= brightness_level_next;
      volume_changed     <= vol_step_changed;
      brightness_changed <= bri_step_changed;
    end
  end

endmodule

FILE: hw/rtl/kalc_checker.sv
// Port-level checks for the key auto-repeat level controller.
// Depends on kalc_pkg and assert_macros.svh; bound to the top level below.
`include "assert_macros.svh"

module kalc_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input kalc_pkg::level_t                    volume,
  input kalc_pkg::level_t                    brightness,
  input logic                                volume_changed,
  input logic                                brightness_changed
);
  import kalc_pkg::*;

  `KALC_ASSERT_NEXT(a_accept_gives_result, clk, rst, in_valid && in_ready, out_valid, "accepted request produced no result")

  `KALC_ASSERT_IMPLIES(a_stall_blocks_input, clk, rst, out_valid && !out_ready, !in_ready, "request taken while result stalled")

  `KALC_ASSERT_IMPLIES(a_one_level_stepped, clk, rst, out_valid, !(volume_changed && brightness_changed), "both levels stepped by one request")

  `KALC_ASSERT_NEXT(a_stalled_result_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(volume) && $stable(brightness), "stalled result changed")

endmodule

bind key_autorepeat_level_control_core kalc_checker u_kalc_checker (.*);

FILE: tb/sv/key_autorepeat_level_control_core_tb.sv
// Self-checking testbench for the key auto-repeat level controller.
// Drives frame and key requests with random flow control, predicts every
// result in-bench and checks it; depends on kalc_pkg and the core RTL.
`timescale 1ns / 100ps

module key_autorepeat_level_control_core_tb;
  import kalc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    level_t volume;
    level_t brightness;
    logic   volume_changed;
    logic   brightness_changed;
  } levels_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                op = '0;
  logic                      is_key_event = 1'b0;
  logic [KEY_CODE_BITS-1:0]  key_code = '0;
  logic [1:0]                key_value = '0;
  logic [31:0]               now_ms = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  level_t                    volume;
  level_t                    brightness;
  logic                      volume_changed;
  logic                      brightness_changed;

  key_autorepeat_level_control_core i_dut (.*);

  always #4 clk = ~clk;

  // predictor state and register copies
  level_t      vol_max_c, bri_max_c, vol_init_c, bri_init_c;
  ms_t         first_delay_c, interval_c, sleep_gap_c;
  logic        menu_held, up_held, up_fresh, dn_held, dn_fresh;
  logic        have_prev, skipping;
  logic [31:0] up_due, dn_due, frame_ms, prev_frame_ms;
  level_t      vol_lvl, bri_lvl;

  levels_t     expected_levels[$];
  int          fail_count = 0;
  int          n_sent = 0;
  int          n_checked = 0;
  int          n_settings = 1;
  int          burst_left = 0;
  bit          sender_gaps = 1'b1;
  logic [31:0] cur_ms = '0;

  int          hold_token = 0;
  int          long_hold_cycles = 0;
  int          seen_token = 0;
  int          hold_left = 0;
  int          rx_mode = 0;
  int          mode_left = 0;

  function automatic level_t next_level(input level_t lvl, input level_t lim, input logic up);
    if (up) return (lvl < lim) ? lvl + 1'b1 : lvl;
    return (lvl != '0) ? lvl - 1'b1 : lvl;
  endfunction

  function automatic levels_t predict_levels(input logic [1:0] op_v, input logic key_v,
                                             input logic [9:0] code_v, input logic [1:0] val_v,
                                             input logic [31:0] now_v);
    levels_t     r;
    logic        on;
    logic [31:0] armed;
    level_t      nxt;
    r.volume_changed = 1'b0;
    r.brightness_changed = 1'b0;
    case (op_v)
      OP_FRAME_BEGIN: begin
        frame_ms = now_v;
        skipping = have_prev && ((now_v - prev_frame_ms) > {16'd0, sleep_gap_c});
      end
      OP_KEY_EVENT: begin
        if (!skipping && key_v && val_v != KEY_IGNORED) begin
          on = (val_v != KEY_RELEASED);
          armed = frame_ms + {16'd0, first_delay_c};
          if (code_v == KEY_MENU) begin
            menu_held = on;
          end else if (code_v == KEY_PLUS) begin
            up_held = on;
            up_fresh = on;
            if (on) up_due = armed;
          end else if (code_v == KEY_MINUS) begin
            dn_held = on;
            dn_fresh = on;
            if (on) dn_due = armed;
          end
        end
      end
      OP_FRAME_END: begin
        if (skipping) begin
          {menu_held, up_held, up_fresh, dn_held, dn_fresh} = '0;
          up_due = '0;
          dn_due = '0;
        end
        if (up_fresh || (up_held && frame_ms >= up_due)) begin
          if (menu_held) begin
            nxt = next_level(bri_lvl, bri_max_c, 1'b1);
            r.brightness_changed = r.brightness_changed | (nxt != bri_lvl);
            bri_lvl = nxt;
          end else begin
            nxt = next_level(vol_lvl, vol_max_c, 1'b1);
            r.volume_changed = r.volume_changed | (nxt != vol_lvl);
            vol_lvl = nxt;
          end
          if (up_fresh) up_fresh = 1'b0;
          else up_due = up_due + {16'd0, interval_c};
        end
        if (dn_fresh || (dn_held && frame_ms >= dn_due)) begin
          if (menu_held) begin
            nxt = next_level(bri_lvl, bri_max_c, 1'b0);
            r.brightness_changed = r.brightness_changed | (nxt != bri_lvl);
            bri_lvl = nxt;
          end else begin
            nxt = next_level(vol_lvl, vol_max_c, 1'b0);
            r.volume_changed = r.volume_changed | (nxt != vol_lvl);
            vol_lvl = nxt;
          end
          if (dn_fresh) dn_fresh = 1'b0;
          else dn_due = dn_due + {16'd0, interval_c};
        end
        prev_frame_ms = frame_ms;
        have_prev = 1'b1;
        skipping = 1'b0;
      end
      default: ;
    endcase
    r.volume = vol_lvl;
    r.brightness = bri_lvl;
    return r;
  endfunction

  task automatic send_req(input logic [1:0] op_v, input logic key_v, input logic [9:0] code_v,
                          input logic [1:0] val_v, input logic [31:0] now_v);
    int gap;
    if (burst_left == 0) begin
      gap = sender_gaps ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid     <= 1'b1;
    op           <= op_v;
    is_key_event <= key_v;
    key_code     <= code_v;
    key_value    <= val_v;
    now_ms       <= now_v;
    do @(posedge clk); while (!in_ready);
    expected_levels.push_back(predict_levels(op_v, key_v, code_v, val_v, now_v));
    n_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // write all registers, plus the unused index, with junk in unused upper bits
  task automatic apply_settings(input int vmax, input int bmax, input int vinit, input int binit,
                                input int delay_ms, input int interval_ms, input int gap_ms);
    logic [15:0] vals[8];
    logic [15:0] word;
    vals[REG_VOLUME_MAX]      = vmax;
    vals[REG_BRIGHTNESS_MAX]  = bmax;
    vals[REG_VOLUME_INIT]     = vinit;
    vals[REG_BRIGHTNESS_INIT] = binit;
    vals[REG_FIRST_DELAY]     = delay_ms;
    vals[REG_REPEAT_INTERVAL] = interval_ms;
    vals[REG_SLEEP_GAP]       = gap_ms;
    vals[REG_UNUSED]          = $urandom_range(0, 65535);
    drain_results();
    for (int i = 0; i < 8; i++) begin
      word = vals[i];
      if (i <= REG_BRIGHTNESS_INIT) word[15:6] = $urandom_range(0, 1023);
      cfg_we    <= 1'b1;
      cfg_index <= i;
      cfg_data  <= word;
      @(posedge clk);
      case (i)
        REG_VOLUME_MAX:      vol_max_c = word[5:0];
        REG_BRIGHTNESS_MAX:  bri_max_c = word[5:0];
        REG_VOLUME_INIT:     begin vol_init_c = word[5:0]; vol_lvl = word[5:0]; end
        REG_BRIGHTNESS_INIT: begin bri_init_c = word[5:0]; bri_lvl = word[5:0]; end
        REG_FIRST_DELAY:     first_delay_c = word;
        REG_REPEAT_INTERVAL: interval_c = word;
        REG_SLEEP_GAP:       sleep_gap_c = word;
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // mostly well-formed frames with random content, some stray requests
  task automatic run_frames(input int n_req, input bit steady);
    int          sent_here;
    int          n_keys;
    int          pick;
    logic [1:0]  op_v;
    logic [31:0] delta;
    logic [31:0] stamp;
    logic [9:0]  code_v;
    logic [1:0]  val_v;
    sent_here = 0;
    if (steady) sender_gaps = 1'b0;
    while (sent_here < n_req) begin
      if (!steady && $urandom_range(0, 19) == 0) sender_gaps = !sender_gaps;
      if ($urandom_range(0, 99) < 8) begin
        op_v = $urandom_range(0, 3);
        stamp = $urandom;
        if (op_v == OP_FRAME_BEGIN) cur_ms = stamp;
        send_req(op_v, $urandom_range(0, 1), $urandom_range(0, 1023), $urandom_range(0, 3), stamp);
        sent_here++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) delta = $urandom_range(0, 120);
        else if (pick < 75) delta = {16'd0, sleep_gap_c} + $urandom_range(0, 2) - 1;
        else if (pick < 85) delta = '0;
        else if (pick < 95) delta = $urandom_range(0, 70000);
        else delta = $urandom;
        cur_ms = cur_ms + delta;
        send_req(OP_FRAME_BEGIN, $urandom_range(0, 1), $urandom_range(0, 1023),
                 $urandom_range(0, 3), cur_ms);
        n_keys = $urandom_range(0, 5);
        if (n_keys > 3) n_keys = 0;
        repeat (n_keys) begin
          pick = $urandom_range(0, 99);
          if (pick < 30) code_v = KEY_PLUS;
          else if (pick < 60) code_v = KEY_MINUS;
          else if (pick < 85) code_v = KEY_MENU;
          else code_v = $urandom_range(0, 1023);
          pick = $urandom_range(0, 99);
          if (pick < 35) val_v = KEY_PRESSED;
          else if (pick < 65) val_v = KEY_RELEASED;
          else if (pick < 90) val_v = KEY_REPEAT;
          else val_v = KEY_IGNORED;
          send_req(OP_KEY_EVENT, $urandom_range(0, 12) != 0, code_v, val_v, $urandom);
        end
        send_req(OP_FRAME_END, $urandom_range(0, 1), $urandom_range(0, 1023),
                 $urandom_range(0, 3), $urandom);
        sent_here += n_keys + 2;
      end
    end
    sender_gaps = 1'b1;
  endtask

  task automatic test_directed_sequence();
    send_req(OP_FRAME_BEGIN, 1'b1, 10'h3FF, KEY_IGNORED, 32'd0);
    send_req(OP_KEY_EVENT, 1'b1, KEY_PLUS, KEY_PRESSED, 32'hFFFF_FFFF);
    send_req(OP_FRAME_END, 1'b0, 10'd0, KEY_RELEASED, 32'd0);
    send_req(OP_FRAME_BEGIN, 1'b0, 10'd0, KEY_RELEASED, 32'd100);
    send_req(OP_KEY_EVENT, 1'b1, KEY_PLUS, KEY_REPEAT, 32'd0);
    send_req(OP_FRAME_END, 1'b1, 10'h3FF, KEY_IGNORED, 32'hFFFF_FFFF);
    // held past the first delay: auto-repeat step
    send_req(OP_FRAME_BEGIN, 1'b0, 10'd0, KEY_RELEASED, 32'd450);
    send_req(OP_FRAME_END, 1'b0, 10'd0, KEY_RELEASED, 32'd0);
    // menu held steers steps to brightness; down at zero saturates
    send_req(OP_FRAME_BEGIN, 1'b0, 10'd0, KEY_RELEASED, 32'd460);
    send_req(OP_KEY_EVENT, 1'b1, KEY_MENU, KEY_PRESSED, 32'd0);
    send_req(OP_KEY_EVENT, 1'b1, KEY_MINUS, KEY_PRESSED, 32'd0);
    send_req(OP_FRAME_END, 1'b0, 10'd0, KEY_RELEASED, 32'd0);
    // ignored events and the unused op
    send_req(OP_KEY_EVENT, 1'b0, KEY_PLUS, KEY_PRESSED, 32'd0);
    send_req(OP_KEY_EVENT, 1'b1, KEY_PLUS, KEY_IGNORED, 32'd0);
    send_req(OP_KEY_EVENT, 1'b1, 10'h3FF, KEY_PRESSED, 32'd0);
    send_req(OP_UNUSED, 1'b1, KEY_PLUS, KEY_PRESSED, 32'hFFFF_FFFF);
    // press and release within one frame
    send_req(OP_FRAME_BEGIN, 1'b0, 10'd0, KEY_RELEASED, 32'd470);
    send_req(OP_KEY_EVENT, 1'b1, KEY_PLUS, KEY_PRESSED, 32'd0);
    send_req(OP_KEY_EVENT, 1'b1, KEY_PLUS, KEY_RELEASED, 32'd0);
    send_req(OP_FRAME_END, 1'b0, 10'd0, KEY_RELEASED, 32'd0);
    // gap beyond the sleep limit: frame dropped and key state cleared
    send_req(OP_FRAME_BEGIN, 1'b0, 10'd0, KEY_RELEASED, 32'd5000);
    send_req(OP_KEY_EVENT, 1'b1, KEY_PLUS, KEY_PRESSED, 32'd0);
    send_req(OP_FRAME_END, 1'b0, 10'd0, KEY_RELEASED, 32'd0);
    // time wraps through zero
    send_req(OP_FRAME_BEGIN, 1'b0, 10'd0, KEY_RELEASED, 32'hFFFF_FFFF);
    send_req(OP_FRAME_END, 1'b0, 10'd0, KEY_RELEASED, 32'd0);
    cur_ms = 32'd16;
    send_req(OP_FRAME_BEGIN, 1'b0, 10'd0, KEY_RELEASED, cur_ms);
    send_req(OP_KEY_EVENT, 1'b1, KEY_MINUS, KEY_PRESSED, 32'd0);
    send_req(OP_FRAME_END, 1'b0, 10'd0, KEY_RELEASED, 32'd0);
  endtask

  task automatic test_reset_settings();
    run_frames(180, 1'b0);
  endtask

  task automatic test_level_above_max();
    apply_settings(5, 0, 63, 40, 50, 20, 400);
    run_frames(170, 1'b0);
  endtask

  task automatic test_full_range();
    apply_settings(63, 63, 0, 63, 65535, 65535, 65535);
    run_frames(150, 1'b0);
  endtask

  task automatic test_zero_timing();
    apply_settings(3, 2, 1, 1, 0, 0, 0);
    run_frames(170, 1'b0);
  endtask

  task automatic test_random_settings();
    apply_settings($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 63), $urandom_range(0, 600), $urandom_range(1, 400),
                   $urandom_range(50, 2000));
    run_frames(150, 1'b0);
  endtask

  task automatic test_backpressure();
    apply_settings(20, 10, 7, 3, 300, 100, 1000);
    long_hold_cycles = 80;
    hold_token++;
    run_frames(60, 1'b1);
  endtask

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
    end else if (hold_token != seen_token) begin
      seen_token <= hold_token;
      hold_left  <= long_hold_cycles;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   <= $urandom_range(0, 3);
        mode_left <= $urandom_range(16, 160);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    levels_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_levels.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = expected_levels.pop_front();
        if (volume !== want.volume) begin
          $error("volume: expected %0d, got %0d", want.volume, volume);
          fail_count++;
        end
        if (brightness !== want.brightness) begin
          $error("brightness: expected %0d, got %0d", want.brightness, brightness);
          fail_count++;
        end
        if (volume_changed !== want.volume_changed) begin
          $error("volume_changed: expected %0d, got %0d", want.volume_changed, volume_changed);
          fail_count++;
        end
        if (brightness_changed !== want.brightness_changed) begin
          $error("brightness_changed: expected %0d, got %0d", want.brightness_changed,
                 brightness_changed);
          fail_count++;
        end
        n_checked++;
      end
    end
  end

  initial begin
    vol_max_c     = RST_VOLUME_MAX;
    bri_max_c     = RST_BRIGHTNESS_MAX;
    vol_init_c    = RST_VOLUME_INIT;
    bri_init_c    = RST_BRIGHTNESS_INIT;
    first_delay_c = RST_FIRST_DELAY;
    interval_c    = RST_REPEAT_INTERVAL;
    sleep_gap_c   = RST_SLEEP_GAP;
    {menu_held, up_held, up_fresh, dn_held, dn_fresh, have_prev, skipping} = '0;
    {up_due, dn_due, frame_ms, prev_frame_ms} = '0;
    vol_lvl = RST_VOLUME_INIT;
    bri_lvl = RST_BRIGHTNESS_INIT;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_sequence();
    test_reset_settings();
    test_level_above_max();
    test_full_range();
    test_zero_timing();
    test_random_settings();
    test_backpressure();
    drain_results();
    repeat (4) @(posedge clk);
    $display("Covered %0d requests and %0d checked results over %0d register settings,",
             n_sent, n_checked, n_settings);
    $display("with saturation, dropped frames, time wrap and a long output stall.");
    if (fail_count == 0) begin
      $display("key_autorepeat_level_control_core verification clean");
    end else begin
      $display("key_autorepeat_level_control_core verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("key_autorepeat_level_control_core verification failed");
    $finish;
  end

endmodule
